/* hw/rtl/stack_frame_allocator_defines.svh */
// assertion macros for the stack frame allocator
`ifndef STACK_FRAME_ALLOCATOR_DEFINES_SVH
`define STACK_FRAME_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define SFA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sfa assertion failed");
`define SFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sfa assertion failed");
`else
`define SFA_ASSERT_IMP(label, clk, rst, ante, cons)
`define SFA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* hw/rtl/sfa_pkg.sv */
package sfa_pkg;

   localparam int OFFSET_BITS = 21;
   localparam int ADDR_BITS   = 32;
   localparam int ALIGN_BITS  = 3;
   localparam int CSR_IDX_BITS = 2;

   typedef logic [1:0]             mode_type;
   typedef logic [1:0]             status_type;
   typedef logic [OFFSET_BITS-1:0] offset_type;
   typedef logic [ADDR_BITS-1:0]   addr_type;
   typedef logic [CSR_IDX_BITS-1:0] csr_idx_type;

   localparam mode_type MODE_PUSH   = 2'd0;
   localparam mode_type MODE_POP    = 2'd1;
   localparam mode_type MODE_CLEAR  = 2'd2;
   localparam mode_type MODE_REPORT = 2'd3;

   localparam status_type STATUS_OK     = 2'd0;
   localparam status_type STATUS_NO_MEM = 2'd1;
   localparam status_type STATUS_EMPTY  = 2'd2;
   localparam status_type STATUS_FULL   = 2'd3;

   localparam csr_idx_type CSR_CAPACITY = 2'd0;
   localparam csr_idx_type CSR_BASE     = 2'd1;

   localparam offset_type CAPACITY_RESET = 21'h100000;

endpackage

/* hw/rtl/sfa_ifs.sv */
interface sfa_req_if import sfa_pkg::*; ();
   logic                  valid;
   logic                  ready;
   mode_type              mode;
   offset_type            request_bytes;
   logic [ALIGN_BITS-1:0] align_log2;

   modport source(output valid, mode, request_bytes, align_log2, input ready);
   modport sink(input valid, mode, request_bytes, align_log2, output ready);
endinterface

interface sfa_rsp_if import sfa_pkg::*; ();
   logic       valid;
   logic       ready;
   status_type status;
   addr_type   block_address;
   offset_type frame_bytes;
   offset_type used_bytes;
   offset_type free_bytes;

   modport source(output valid, status, block_address, frame_bytes, used_bytes,
                  free_bytes, input ready);
   modport sink(input valid, status, block_address, frame_bytes, used_bytes,
                free_bytes, output ready);
endinterface

interface sfa_csr_if import sfa_pkg::*; ();
   logic        valid;
   logic        ready;
   csr_idx_type index;
   addr_type    data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

/* hw/rtl/stack_frame_allocator.sv */
// Stack (LIFO) allocator over one region of capacity_bytes starting at base_address.
// A push adds HEADER_BYTES to the request, rounds up to 1 << align_log2 and, if
// the frame fits and the frame store has room for MAX_FRAMES entries, returns
// base plus the old head. A pop releases the newest frame, whose size comes from
// a one-port synchronous frame-size memory. Every item yields one result with
// used and free bytes. The accept cycle registers an item and reads the top entry
// of the frame-size memory; the execute state then does the add, fit check and
// head update and loads the output register once that register is free. A new
// item is taken once the previous one has reached the output register, even while
// that result still waits to be taken. Registers written on the csr port take
// effect for the next item; write them only while no item is in flight.
`include "stack_frame_allocator_defines.svh"

module stack_frame_allocator import sfa_pkg::*; #(
   parameter int MAX_FRAMES   = 64,
   parameter int HEADER_BYTES = 4
) (
   input logic     clock,
   input logic     reset,
   sfa_req_if.sink   req_ch,
   sfa_rsp_if.source rsp_ch,
   sfa_csr_if.sink   csr_ch
);

   localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
   localparam int IDX_W  = $clog2(MAX_FRAMES);
   localparam int SIZE_W = OFFSET_BITS + 1;
   localparam int FIT_W  = OFFSET_BITS + 2;
   localparam int MASK_W = 1 << ALIGN_BITS;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic                  state_ff, state_in;
   offset_type            capacity_ff;
   addr_type              base_ff;
   offset_type            head_ff, head_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   mode_type              mode_ff;
   offset_type            req_bytes_ff;
   logic [ALIGN_BITS-1:0] align_ff;
   offset_type            rd_data_ff;
   offset_type            frame_mem [MAX_FRAMES];

   logic                  rsp_valid_ff;
   status_type            rsp_status_ff, rsp_status_in;
   addr_type              rsp_addr_ff, rsp_addr_in;
   offset_type            rsp_bytes_ff, rsp_bytes_in;
   offset_type            rsp_used_ff;
   offset_type            rsp_free_ff, rsp_free_in;

   logic                  accept;
   logic                  out_free;
   logic                  finish;
   logic                  mem_we;
   logic [CNT_W-1:0]      count_dec;
   logic [IDX_W-1:0]      rd_idx;
   logic [MASK_W-1:0]     align_mask;
   logic [SIZE_W-1:0]     size_sum;
   logic [SIZE_W-1:0]     push_size;
   logic [FIT_W-1:0]      fit_sum;
   logic                  push_fits;
   logic                  store_full;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign finish       = (state_ff == ST_EXEC) && out_free;
   assign csr_ch.ready = 1'b1;

   assign count_dec = count_ff - CNT_W'(1);
   assign rd_idx    = count_dec[IDX_W-1:0];

   // frame size and fit check
   assign align_mask = MASK_W'((MASK_W+1)'(1) << align_ff) - MASK_W'(1);
   assign size_sum   = SIZE_W'(req_bytes_ff) + SIZE_W'(HEADER_BYTES) + SIZE_W'(align_mask);
   assign push_size  = size_sum & ~SIZE_W'(align_mask);
   assign fit_sum    = FIT_W'(head_ff) + FIT_W'(push_size);
   assign push_fits  = !(fit_sum > FIT_W'(capacity_ff));
   assign store_full = (count_ff >= CNT_W'(MAX_FRAMES));

   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      mem_we        = 1'b0;
      rsp_status_in = STATUS_OK;
      rsp_addr_in   = '0;
      rsp_bytes_in  = '0;
      unique case (mode_ff)
         MODE_PUSH: begin
            if (!push_fits) begin
               rsp_status_in = STATUS_NO_MEM;
            end else if (store_full) begin
               rsp_status_in = STATUS_FULL;
            end else begin
               mem_we       = finish;
               rsp_addr_in  = base_ff + {{(ADDR_BITS-OFFSET_BITS){1'b0}}, head_ff};
               rsp_bytes_in = push_size[OFFSET_BITS-1:0];
               head_in      = fit_sum[OFFSET_BITS-1:0];
               count_in     = count_ff + CNT_W'(1);
            end
         end
         MODE_POP: begin
            if (count_ff == '0) begin
               rsp_status_in = STATUS_EMPTY;
            end else begin
               rsp_bytes_in = rd_data_ff;
               head_in      = (rd_data_ff > head_ff) ? '0 : head_ff - rd_data_ff;
               count_in     = count_dec;
            end
         end
         MODE_CLEAR: begin
            head_in  = '0;
            count_in = '0;
         end
         MODE_REPORT: begin
         end
         default: begin
         end
      endcase
      rsp_free_in = (capacity_ff > head_in) ? capacity_ff - head_in : '0;
   end

   always_comb begin
      state_in = state_ff;
      if (accept) begin
         state_in = ST_EXEC;
      end else if (finish) begin
         state_in = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         capacity_ff  <= CAPACITY_RESET;
         base_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (finish) begin
            head_ff  <= head_in;
            count_ff <= count_in;
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_ch.valid && csr_ch.ready) begin
            if (csr_ch.index == CSR_CAPACITY) begin
               capacity_ff <= csr_ch.data[OFFSET_BITS-1:0];
            end else if (csr_ch.index == CSR_BASE) begin
               base_ff <= csr_ch.data;
            end
         end
      end
   end

   // item and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff      <= req_ch.mode;
         req_bytes_ff <= req_ch.request_bytes;
         align_ff     <= req_ch.align_log2;
      end
      if (finish) begin
         rsp_status_ff <= rsp_status_in;
         rsp_addr_ff   <= rsp_addr_in;
         rsp_bytes_ff  <= rsp_bytes_in;
         rsp_used_ff   <= head_in;
         rsp_free_ff   <= rsp_free_in;
      end
   end

   // frame size store, top entry read on accept
   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[count_ff[IDX_W-1:0]] <= push_size[OFFSET_BITS-1:0];
      end
      if (accept) begin
         rd_data_ff <= frame_mem[rd_idx];
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_status_ff;
   assign rsp_ch.block_address = rsp_addr_ff;
   assign rsp_ch.frame_bytes   = rsp_bytes_ff;
   assign rsp_ch.used_bytes    = rsp_used_ff;
   assign rsp_ch.free_bytes    = rsp_free_ff;

   `SFA_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_FRAMES))
   `SFA_ASSERT_IMP(a_empty_head, clock, reset, count_ff == '0, head_ff == '0)
   `SFA_ASSERT_NEXT(a_push_count, clock, reset, finish && (mode_ff == MODE_PUSH) && (rsp_status_in == STATUS_OK), count_ff == $past(count_ff) + CNT_W'(1))
   `SFA_ASSERT_NEXT(a_accept_exec, clock, reset, accept, (state_ff == ST_EXEC) && $stable(count_ff))

endmodule
